// File: rtl/pgms_pkg.sv
// Shared types and constants for the pose geofence mode selector.
// Holds the CORDIC arctangent table, the rotation gain and the register index codes.
// No dependencies.
`default_nettype none

package pgms_pkg;

    // Internal angles are fractions of a turn in this many bits
    localparam int TURN_BITS = 32;

    // CORDIC rotation gain 1/K in Q30
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Quarter turn and the Q2.28 unit used by the quaternion terms
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] ONE_Q28      = 34'sd268435456;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_OFFSET_X       = 3'd0,
        REG_OFFSET_Y       = 3'd1,
        REG_OFFSET_ANGLE   = 3'd2,
        REG_X_BOUNDS       = 3'd3,
        REG_Y_BOUNDS       = 3'd4,
        REG_TARGET_HEADING = 3'd5,
        REG_HEADING_TOL    = 3'd6,
        REG_LEG_AND_SPIN   = 3'd7
    } cfg_reg_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [TURN_BITS-1:0] atan_lut(input int idx);
        logic [TURN_BITS-1:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pgms_quat_front.sv
// Quaternion front end: forms the yaw atan2 operands and the gimbal lock test.
// Two register stages (products, then sums). Depends on pgms_pkg.
`default_nettype none

module pgms_quat_front
    import pgms_pkg::*;
#(
    parameter int POS_BITS = 20
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic signed [POS_BITS-1:0] odom_x,
    input  wire logic signed [POS_BITS-1:0] odom_y,
    input  wire logic signed [15:0]         quat_x,
    input  wire logic signed [15:0]         quat_y,
    input  wire logic signed [15:0]         quat_z,
    input  wire logic signed [15:0]         quat_w,
    output logic                            out_valid,
    output logic signed [33:0]              num,
    output logic signed [33:0]              den,
    output logic                            yaw_ok,
    output logic signed [POS_BITS-1:0]      px,
    output logic signed [POS_BITS-1:0]      py
);

    logic                       va_reg;
    logic signed [31:0]         pxy_reg, pwz_reg, pyy_reg, pzz_reg, pxz_reg, pwy_reg;
    logic signed [POS_BITS-1:0] pxa_reg, pya_reg;

    logic                       vb_reg;
    logic signed [33:0]         num_reg, den_reg;
    logic                       ok_reg;
    logic signed [POS_BITS-1:0] pxb_reg, pyb_reg;

    logic signed [33:0]         num_next, den_next, m20_next;
    logic                       ok_next;

    // Stage A valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv)
            va_reg <= in_valid;
    end

    // Stage A: quaternion products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxy_reg <= quat_x * quat_y;
            pwz_reg <= quat_w * quat_z;
            pyy_reg <= quat_y * quat_y;
            pzz_reg <= quat_z * quat_z;
            pxz_reg <= quat_x * quat_z;
            pwy_reg <= quat_w * quat_y;
            pxa_reg <= odom_x;
            pya_reg <= odom_y;
        end
    end

    // Sums of products and gimbal lock test
    always_comb
    begin
        num_next = (34'(pxy_reg) + 34'(pwz_reg)) <<< 1;
        den_next = ONE_Q28 - ((34'(pyy_reg) + 34'(pzz_reg)) <<< 1);
        m20_next = (34'(pxz_reg) - 34'(pwy_reg)) <<< 1;
        ok_next  = (m20_next < ONE_Q28) && (m20_next > -ONE_Q28);
    end

    // Stage B valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (adv)
            vb_reg <= va_reg;
    end

    // Stage B payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
            ok_reg  <= ok_next;
            pxb_reg <= pxa_reg;
            pyb_reg <= pya_reg;
        end
    end

    assign out_valid = vb_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign yaw_ok    = ok_reg;
    assign px        = pxb_reg;
    assign py        = pyb_reg;

endmodule

`default_nettype wire

// File: rtl/pgms_cordic.sv
// Pipelined CORDIC pair: vectoring for the yaw angle, rotating for sin and cos
// of the frame offset. One pre-rotation stage plus one stage per iteration.
// Depends on pgms_pkg.
`default_nettype none

module pgms_cordic
    import pgms_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 41
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic signed [33:0]   num,
    input  wire logic signed [33:0]   den,
    input  wire logic [TURN_BITS-1:0] angle,
    input  wire logic [SIDE_W-1:0]    side_in,
    output logic                      out_valid,
    output logic [TURN_BITS-1:0]      yaw_acc,
    output logic signed [33:0]        cos_q,
    output logic signed [33:0]        sin_q,
    output logic [SIDE_W-1:0]         side_out
);

    localparam int CW = 36;

    // Per-stage views; element 0 is the pre-rotation register
    logic                       val_w [0:STAGES];
    logic signed [CW-1:0]       vx_w  [0:STAGES];
    logic signed [CW-1:0]       vy_w  [0:STAGES];
    logic [TURN_BITS-1:0]       acc_w [0:STAGES];
    logic signed [33:0]         rx_w  [0:STAGES];
    logic signed [33:0]         ry_w  [0:STAGES];
    logic signed [33:0]         rz_w  [0:STAGES];
    logic [SIDE_W-1:0]          sd_w  [0:STAGES];

    logic                       pv_reg;
    logic signed [CW-1:0]       pvx_reg, pvy_reg;
    logic [TURN_BITS-1:0]       pacc_reg;
    logic signed [33:0]         prx_reg, pry_reg, prz_reg;
    logic [SIDE_W-1:0]          psd_reg;

    logic signed [CW-1:0]       pvx_next, pvy_next, x0, y0;
    logic [TURN_BITS-1:0]       pacc_next;
    logic signed [33:0]         prx_next, pry_next, prz_next, z0;

    // Pre-rotation into the right half plane and into the +-quarter turn range
    always_comb
    begin
        x0        = CW'(den);
        y0        = CW'(num);
        pvx_next  = x0;
        pvy_next  = y0;
        pacc_next = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                pvx_next  = y0;
                pvy_next  = -x0;
                pacc_next = 32'h4000_0000;
            end
            else
            begin
                pvx_next  = -y0;
                pvy_next  = x0;
                pacc_next = 32'hC000_0000;
            end
        end
        z0       = 34'(signed'(angle));
        prx_next = CORDIC_GAIN_Q30;
        pry_next = '0;
        prz_next = z0;
        if (z0 > QUARTER_TURN)
        begin
            prx_next = '0;
            pry_next = CORDIC_GAIN_Q30;
            prz_next = z0 - QUARTER_TURN;
        end
        else if (z0 < -QUARTER_TURN)
        begin
            prx_next = '0;
            pry_next = -CORDIC_GAIN_Q30;
            prz_next = z0 + QUARTER_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (adv)
            pv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pvx_reg  <= pvx_next;
            pvy_reg  <= pvy_next;
            pacc_reg <= pacc_next;
            prx_reg  <= prx_next;
            pry_reg  <= pry_next;
            prz_reg  <= prz_next;
            psd_reg  <= side_in;
        end
    end

    assign val_w[0] = pv_reg;
    assign vx_w[0]  = pvx_reg;
    assign vy_w[0]  = pvy_reg;
    assign acc_w[0] = pacc_reg;
    assign rx_w[0]  = prx_reg;
    assign ry_w[0]  = pry_reg;
    assign rz_w[0]  = prz_reg;
    assign sd_w[0]  = psd_reg;

    // Micro-rotation stages
    for (genvar gi = 0; gi < STAGES; gi++)
    begin : g_stage
        localparam logic [TURN_BITS-1:0] ATAN = atan_lut(gi);

        logic                 v_reg;
        logic signed [CW-1:0] vx_reg, vy_reg, vx_next, vy_next;
        logic [TURN_BITS-1:0] acc_reg, acc_next;
        logic signed [33:0]   rx_reg, ry_reg, rz_reg, rx_next, ry_next, rz_next;
        logic [SIDE_W-1:0]    sd_reg;

        always_comb
        begin
            // Vectoring: drive y toward zero
            if (vy_w[gi] >= 0)
            begin
                vx_next  = vx_w[gi] + (vy_w[gi] >>> gi);
                vy_next  = vy_w[gi] - (vx_w[gi] >>> gi);
                acc_next = acc_w[gi] + ATAN;
            end
            else
            begin
                vx_next  = vx_w[gi] - (vy_w[gi] >>> gi);
                vy_next  = vy_w[gi] + (vx_w[gi] >>> gi);
                acc_next = acc_w[gi] - ATAN;
            end
            // Rotating: drive z toward zero
            if (rz_w[gi] >= 0)
            begin
                rx_next = rx_w[gi] - (ry_w[gi] >>> gi);
                ry_next = ry_w[gi] + (rx_w[gi] >>> gi);
                rz_next = rz_w[gi] - signed'({2'b00, ATAN});
            end
            else
            begin
                rx_next = rx_w[gi] + (ry_w[gi] >>> gi);
                ry_next = ry_w[gi] - (rx_w[gi] >>> gi);
                rz_next = rz_w[gi] + signed'({2'b00, ATAN});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= val_w[gi];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                vx_reg  <= vx_next;
                vy_reg  <= vy_next;
                acc_reg <= acc_next;
                rx_reg  <= rx_next;
                ry_reg  <= ry_next;
                rz_reg  <= rz_next;
                sd_reg  <= sd_w[gi];
            end
        end

        assign val_w[gi+1] = v_reg;
        assign vx_w[gi+1]  = vx_reg;
        assign vy_w[gi+1]  = vy_reg;
        assign acc_w[gi+1] = acc_reg;
        assign rx_w[gi+1]  = rx_reg;
        assign ry_w[gi+1]  = ry_reg;
        assign rz_w[gi+1]  = rz_reg;
        assign sd_w[gi+1]  = sd_reg;
    end

    assign out_valid = val_w[STAGES];
    assign yaw_acc   = acc_w[STAGES];
    assign cos_q     = rx_w[STAGES];
    assign sin_q     = ry_w[STAGES];
    assign side_out  = sd_w[STAGES];

endmodule

`default_nettype wire

// File: rtl/pgms_map_back.sv
// Back end: frame transform, region and heading tests, mode select.
// Three register stages, the last one being the output register. Depends on pgms_pkg.
`default_nettype none

module pgms_map_back
    import pgms_pkg::*;
#(
    parameter int POS_BITS   = 20,
    parameter int ANGLE_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic [TURN_BITS-1:0]         yaw_acc,
    input  wire logic                         yaw_ok,
    input  wire logic signed [33:0]           cos_q,
    input  wire logic signed [33:0]           sin_q,
    input  wire logic signed [POS_BITS-1:0]   px,
    input  wire logic signed [POS_BITS-1:0]   py,
    input  wire logic signed [POS_BITS-1:0]   offset_x,
    input  wire logic signed [POS_BITS-1:0]   offset_y,
    input  wire logic [ANGLE_BITS-1:0]        offset_angle,
    input  wire logic [2*POS_BITS-1:0]        x_bounds,
    input  wire logic [2*POS_BITS-1:0]        y_bounds,
    input  wire logic [ANGLE_BITS-1:0]        target_heading,
    input  wire logic [15:0]                  heading_tolerance,
    input  wire logic [23:0]                  leg_and_spin,
    output logic                              out_valid,
    output logic [7:0]                        leg_code,
    output logic [7:0]                        spin_code,
    output logic                              box_hit,
    output logic                              hdg_ok,
    output logic signed [POS_BITS-1:0]        map_x,
    output logic signed [POS_BITS-1:0]        map_y,
    output logic signed [ANGLE_BITS-1:0]      heading_error
);

    localparam int PROD_W = 32 + POS_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAP_W  = POS_BITS + 4;
    localparam int CMP_W  = (ANGLE_BITS + 1 > 16) ? ANGLE_BITS + 1 : 16;
    localparam logic [TURN_BITS-1:0] YAW_ROUND = TURN_BITS'(1) << (31 - ANGLE_BITS);
    localparam logic signed [SUM_W-1:0] HALF_Q30 = SUM_W'(64'sd536870912);
    localparam logic signed [MAP_W-1:0] SAT_HI = MAP_W'((64'sd1 <<< (POS_BITS - 1)) - 1);
    localparam logic signed [MAP_W-1:0] SAT_LO = MAP_W'(-(64'sd1 <<< (POS_BITS - 1)));

    // Stage 1: rotation products and rounded yaw
    logic                       v1_reg;
    logic signed [PROD_W-1:0]   cpx_reg, spy_reg, spx_reg, cpy_reg;
    logic [ANGLE_BITS-1:0]      yaw_reg, yaw_next;
    logic [TURN_BITS-1:0]       yaw_round;
    logic signed [31:0]         c32, s32;

    always_comb
    begin
        c32       = 32'(cos_q);
        s32       = 32'(sin_q);
        yaw_round = yaw_acc + YAW_ROUND;
        yaw_next  = yaw_ok ? yaw_round[TURN_BITS-1 -: ANGLE_BITS] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cpx_reg <= c32 * px;
            spy_reg <= s32 * py;
            spx_reg <= s32 * px;
            cpy_reg <= c32 * py;
            yaw_reg <= yaw_next;
        end
    end

    // Stage 2: round, translate, heading error
    logic                       v2_reg;
    logic signed [MAP_W-1:0]    mx_reg, my_reg, mx_next, my_next;
    logic [ANGLE_BITS-1:0]      err_reg, err_next;
    logic signed [SUM_W-1:0]    sx, sy;

    always_comb
    begin
        sx       = SUM_W'(cpx_reg) - SUM_W'(spy_reg) + HALF_Q30;
        sy       = SUM_W'(spx_reg) + SUM_W'(cpy_reg) + HALF_Q30;
        mx_next  = MAP_W'(offset_x) + MAP_W'(sx >>> 30);
        my_next  = MAP_W'(offset_y) + MAP_W'(sy >>> 30);
        err_next = yaw_reg + offset_angle - target_heading;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            err_reg <= err_next;
        end
    end

    // Stage 3: box test, tolerance test, saturation, leg select
    logic                          v3_reg;
    logic [7:0]                    leg_reg, spin_reg;
    logic                          in_reg, match_reg, in_next, match_next;
    logic signed [POS_BITS-1:0]    mapx_reg, mapy_reg;
    logic signed [ANGLE_BITS-1:0]  herr_reg;
    logic signed [POS_BITS-1:0]    xmin, xmax, ymin, ymax;
    logic signed [ANGLE_BITS:0]    e_ext;
    logic [CMP_W-1:0]              abs_err;
    logic signed [POS_BITS-1:0]    satx, saty;

    always_comb
    begin
        xmin  = signed'(x_bounds[POS_BITS-1:0]);
        xmax  = signed'(x_bounds[2*POS_BITS-1:POS_BITS]);
        ymin  = signed'(y_bounds[POS_BITS-1:0]);
        ymax  = signed'(y_bounds[2*POS_BITS-1:POS_BITS]);
        in_next = (mx_reg >= MAP_W'(xmin)) && (mx_reg <= MAP_W'(xmax)) &&
                  (my_reg >= MAP_W'(ymin)) && (my_reg <= MAP_W'(ymax));
        e_ext   = (ANGLE_BITS + 1)'(signed'(err_reg));
        abs_err = CMP_W'(unsigned'(e_ext[ANGLE_BITS] ? -e_ext : e_ext));
        match_next = abs_err <= CMP_W'(heading_tolerance);
        if (mx_reg > SAT_HI)
            satx = POS_BITS'(SAT_HI);
        else if (mx_reg < SAT_LO)
            satx = POS_BITS'(SAT_LO);
        else
            satx = POS_BITS'(mx_reg);
        if (my_reg > SAT_HI)
            saty = POS_BITS'(SAT_HI);
        else if (my_reg < SAT_LO)
            saty = POS_BITS'(SAT_LO);
        else
            saty = POS_BITS'(my_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            leg_reg   <= (in_next && match_next) ? leg_and_spin[15:8] : leg_and_spin[7:0];
            spin_reg  <= leg_and_spin[23:16];
            in_reg    <= in_next;
            match_reg <= match_next;
            mapx_reg  <= satx;
            mapy_reg  <= saty;
            herr_reg  <= signed'(err_reg);
        end
    end

    assign out_valid     = v3_reg;
    assign leg_code      = leg_reg;
    assign spin_code     = spin_reg;
    assign box_hit       = in_reg;
    assign hdg_ok        = match_reg;
    assign map_x         = mapx_reg;
    assign map_y         = mapy_reg;
    assign heading_error = herr_reg;

endmodule

`default_nettype wire

// File: rtl/pose_geofence_mode_select_unit.sv
// Throughput: one pose per cycle; the whole pipeline advances together and holds
// on output backpressure, so a pose enters whenever the output register is free or taken.
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults.
// Top level: configuration registers, stream ports, front end, CORDIC and back end.
`default_nettype none

module pose_geofence_mode_select_unit
    import pgms_pkg::*;
#(
    parameter int POS_BITS      = 20,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // odom_x, odom_y, quat_x, quat_y, quat_z, quat_w (lowest bit up)
    input  wire logic [((2*POS_BITS+64+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // leg code, spin code, box hit, heading ok, map_x, map_y, heading_error (lowest bit up)
    output logic [((2*POS_BITS+ANGLE_BITS+18+7)/8)*8-1:0] m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_addr,
    input  wire logic [2*POS_BITS-1:0] cfg_wdata
);

    localparam int OUT_W  = ((2*POS_BITS+ANGLE_BITS+18+7)/8)*8;
    localparam int OUT_N  = 2*POS_BITS + ANGLE_BITS + 18;
    localparam int Q0     = 2*POS_BITS;
    localparam int SIDE_W = 2*POS_BITS + 1;

    // Configuration registers
    logic signed [POS_BITS-1:0] offset_x_reg, offset_y_reg;
    logic [ANGLE_BITS-1:0]      offset_angle_reg, target_heading_reg;
    logic [2*POS_BITS-1:0]      x_bounds_reg, y_bounds_reg;
    logic [15:0]                tol_reg;
    logic [23:0]                leg_spin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg       <= '0;
            offset_y_reg       <= '0;
            offset_angle_reg   <= '0;
            x_bounds_reg       <= {POS_BITS'(1000), POS_BITS'(0)};
            y_bounds_reg       <= {POS_BITS'(1000), POS_BITS'(0)};
            target_heading_reg <= '0;
            tol_reg            <= 16'd1820;
            leg_spin_reg       <= 24'd513;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_OFFSET_X:       offset_x_reg       <= signed'(cfg_wdata[POS_BITS-1:0]);
                REG_OFFSET_Y:       offset_y_reg       <= signed'(cfg_wdata[POS_BITS-1:0]);
                REG_OFFSET_ANGLE:   offset_angle_reg   <= cfg_wdata[ANGLE_BITS-1:0];
                REG_X_BOUNDS:       x_bounds_reg       <= cfg_wdata;
                REG_Y_BOUNDS:       y_bounds_reg       <= cfg_wdata;
                REG_TARGET_HEADING: target_heading_reg <= cfg_wdata[ANGLE_BITS-1:0];
                REG_HEADING_TOL:    tol_reg            <= cfg_wdata[15:0];
                REG_LEG_AND_SPIN:   leg_spin_reg       <= cfg_wdata[23:0];
                default:            ;
            endcase
        end
    end

    // Whole pipeline advances when the output register is empty or taken
    logic adv;
    logic out_valid;
    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    // Front end
    logic                       f_valid, f_ok;
    logic signed [33:0]         f_num, f_den;
    logic signed [POS_BITS-1:0] f_px, f_py;

    pgms_quat_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .odom_x    (signed'(s_axis_tdata[POS_BITS-1:0])),
        .odom_y    (signed'(s_axis_tdata[2*POS_BITS-1:POS_BITS])),
        .quat_x    (signed'(s_axis_tdata[Q0+15:Q0])),
        .quat_y    (signed'(s_axis_tdata[Q0+31:Q0+16])),
        .quat_z    (signed'(s_axis_tdata[Q0+47:Q0+32])),
        .quat_w    (signed'(s_axis_tdata[Q0+63:Q0+48])),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .yaw_ok    (f_ok),
        .px        (f_px),
        .py        (f_py)
    );

    // CORDIC pair; position and gimbal flag ride along
    logic                       c_valid;
    logic [TURN_BITS-1:0]       c_acc;
    logic signed [33:0]         c_cos, c_sin;
    logic [SIDE_W-1:0]          c_side;
    logic [TURN_BITS-1:0]       off_turn;

    assign off_turn = {offset_angle_reg, (TURN_BITS-ANGLE_BITS)'(0)};

    pgms_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .angle     (off_turn),
        .side_in   ({f_ok, f_py, f_px}),
        .out_valid (c_valid),
        .yaw_acc   (c_acc),
        .cos_q     (c_cos),
        .sin_q     (c_sin),
        .side_out  (c_side)
    );

    // Back end
    logic [7:0]                   r_leg, r_spin;
    logic                         r_in, r_match;
    logic signed [POS_BITS-1:0]   r_mx, r_my;
    logic signed [ANGLE_BITS-1:0] r_err;

    pgms_map_back #(
        .POS_BITS   (POS_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .in_valid          (c_valid),
        .yaw_acc           (c_acc),
        .yaw_ok            (c_side[SIDE_W-1]),
        .cos_q             (c_cos),
        .sin_q             (c_sin),
        .px                (signed'(c_side[POS_BITS-1:0])),
        .py                (signed'(c_side[2*POS_BITS-1:POS_BITS])),
        .offset_x          (offset_x_reg),
        .offset_y          (offset_y_reg),
        .offset_angle      (offset_angle_reg),
        .x_bounds          (x_bounds_reg),
        .y_bounds          (y_bounds_reg),
        .target_heading    (target_heading_reg),
        .heading_tolerance (tol_reg),
        .leg_and_spin      (leg_spin_reg),
        .out_valid         (out_valid),
        .leg_code          (r_leg),
        .spin_code         (r_spin),
        .box_hit           (r_in),
        .hdg_ok            (r_match),
        .map_x             (r_mx),
        .map_y             (r_my),
        .heading_error     (r_err)
    );

    // Pack the result
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = OUT_W'({r_err, r_my, r_mx, r_match, r_in, r_spin, r_leg});

    // A full, stalled output register must block the input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input ready low while output register empty");

    // Nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge clk)
        $past(rst_n) == 1'b0 |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A held pipeline keeps the result payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(m_axis_tdata[OUT_N-1:0]))
        else $error("result changed during stall");

    // Stair code only when both tests pass
    a_leg_select: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !(r_in && r_match) && $stable(leg_spin_reg)
            |-> r_leg == leg_spin_reg[7:0] || !$past(adv))
        else $error("flat leg code not selected");

endmodule

`default_nettype wire

// File: test/pose_geofence_mode_select_unit_tb.sv
// Self-checking testbench for pose_geofence_mode_select_unit.
// Drives odometry poses through the stream ports and checks every result against
// its own predictor. Depends on pgms_pkg and the unit RTL.
`timescale 1ns / 100ps

module pose_geofence_mode_select_unit_tb
    import pgms_pkg::*;
;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  PIPE_DRAIN    = 40;
    localparam int  RAND_PER_PASS = 290;

    // Fields of one result
    typedef struct packed {
        logic [15:0]        herr;
        logic signed [19:0] my;
        logic signed [19:0] mx;
        logic               match;
        logic               box_hit;
        logic [7:0]         spin;
        logic [7:0]         leg;
    } pose_result_t;

    // One row of the directed stimulus table
    typedef struct {
        logic [19:0]  px;
        logic [19:0]  py;
        logic [15:0]  qx;
        logic [15:0]  qy;
        logic [15:0]  qz;
        logic [15:0]  qw;
        bit           typed;
        pose_result_t want;
    } pose_row_t;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_STEP [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [39:0]  cfg_wdata = '0;

    // Shadow copy of the configuration registers
    logic [19:0] sh_offx = '0;
    logic [19:0] sh_offy = '0;
    logic [15:0] sh_angle = '0;
    logic [39:0] sh_xb = 40'd1000 << 20;
    logic [39:0] sh_yb = 40'd1000 << 20;
    logic [15:0] sh_target = '0;
    logic [15:0] sh_tol = 16'd1820;
    logic [23:0] sh_leg = 24'd513;

    pose_result_t pending_results[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           cycles = 0;
    bit           failed = 1'b0;

    pose_geofence_mode_select_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Vectoring CORDIC: atan2(y, x) as a 2^-32 turn fraction
    function automatic logic [31:0] yaw_turns(longint x, longint y);
        logic [31:0] acc;
        longint      t;
        longint      dx;
        longint      dy;
        acc = '0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                acc = 32'h4000_0000;
            end
            else
            begin
                x = -y;
                y = t;
                acc = 32'hC000_0000;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                acc += ATAN_STEP[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                acc -= ATAN_STEP[i];
            end
        end
        return acc;
    endfunction

    // Rotating CORDIC: cos and sin in Q30 of a binary angle
    function automatic void frame_sincos(input logic [15:0] ang, output longint c,
                                         output longint s);
        logic signed [31:0] za;
        longint             z;
        longint             x;
        longint             y;
        longint             dx;
        longint             dy;
        za = {ang, 16'h0};
        z = za;
        x = 652032874;
        y = 0;
        if (z > (longint'(1) << 30))
        begin
            x = 0;
            y = 652032874;
            z -= longint'(1) << 30;
        end
        else if (z < -(longint'(1) << 30))
        begin
            x = 0;
            y = -652032874;
            z += longint'(1) << 30;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_STEP[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_STEP[i]);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [19:0] clamp_pos(longint v);
        if (v > 524287)
            return 20'sd524287;
        if (v < -524288)
            return -20'sd524288;
        return v[19:0];
    endfunction

    // Work out the geofence result of one pose under the shadow configuration
    function automatic pose_result_t geofence_result(logic [103:0] d);
        pose_result_t r;
        longint px, py, qx, qy, qz, qw;
        longint num, den, m20, c, s, mx, my, ae;
        logic [31:0] t;
        logic [15:0] yaw;
        logic [15:0] err;
        logic signed [15:0] e;
        bit in_box;
        px = longint'(signed'(d[19:0]));
        py = longint'(signed'(d[39:20]));
        qx = longint'(signed'(d[55:40]));
        qy = longint'(signed'(d[71:56]));
        qz = longint'(signed'(d[87:72]));
        qw = longint'(signed'(d[103:88]));
        num = 2 * (qx * qy + qw * qz);
        den = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
        m20 = 2 * (qx * qz - qw * qy);
        yaw = '0;
        // Gimbal lock leaves the yaw at zero
        if (m20 < (longint'(1) << 28) && m20 > -(longint'(1) << 28))
        begin
            t = yaw_turns(den, num) + 32'h8000;
            yaw = t[31:16];
        end
        frame_sincos(sh_angle, c, s);
        mx = longint'(signed'(sh_offx)) + ((c * px - s * py + (longint'(1) << 29)) >>> 30);
        my = longint'(signed'(sh_offy)) + ((s * px + c * py + (longint'(1) << 29)) >>> 30);
        in_box = mx >= longint'(signed'(sh_xb[19:0])) && mx <= longint'(signed'(sh_xb[39:20]))
              && my >= longint'(signed'(sh_yb[19:0])) && my <= longint'(signed'(sh_yb[39:20]));
        err = yaw + sh_angle - sh_target;
        e = signed'(err);
        ae = (e < 0) ? -longint'(e) : longint'(e);
        r.match = ae <= longint'(sh_tol);
        r.box_hit = in_box;
        r.leg = (in_box && r.match) ? sh_leg[15:8] : sh_leg[7:0];
        r.spin = sh_leg[23:16];
        r.mx = clamp_pos(mx);
        r.my = clamp_pos(my);
        r.herr = err;
        return r;
    endfunction

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Check result transfers and drive output backpressure
    always @(posedge clk)
    begin
        pose_result_t got;
        pose_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[73:0];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer %h", m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.leg !== want.leg)
                begin
                    $error("leg code expected %0d got %0d", want.leg, got.leg);
                    failed = 1'b1;
                end
                if (got.spin !== want.spin)
                begin
                    $error("spin code expected %0d got %0d", want.spin, got.spin);
                    failed = 1'b1;
                end
                if (got.box_hit !== want.box_hit)
                begin
                    $error("box hit expected %0d got %0d", want.box_hit, got.box_hit);
                    failed = 1'b1;
                end
                if (got.match !== want.match)
                begin
                    $error("heading ok expected %0d got %0d", want.match, got.match);
                    failed = 1'b1;
                end
                if (got.mx !== want.mx)
                begin
                    $error("map_x expected %0d got %0d", want.mx, got.mx);
                    failed = 1'b1;
                end
                if (got.my !== want.my)
                begin
                    $error("map_y expected %0d got %0d", want.my, got.my);
                    failed = 1'b1;
                end
                if (got.herr !== want.herr)
                begin
                    $error("heading_error expected %0d got %0d",
                           signed'(want.herr), signed'(got.herr));
                    failed = 1'b1;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one pose; hold it until transferred, then record its expectation
    task automatic send_pose(input logic [103:0] d, input bit typed, input pose_result_t want);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(typed ? want : geofence_result(d));
    endtask

    // Wait until every result is in and the pipeline is empty
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // Write one register; the caller lowers cfg_we after the batch
    task automatic write_reg(input cfg_reg_t idx, input logic [39:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        case (idx)
            REG_OFFSET_X:       sh_offx = v[19:0];
            REG_OFFSET_Y:       sh_offy = v[19:0];
            REG_OFFSET_ANGLE:   sh_angle = v[15:0];
            REG_X_BOUNDS:       sh_xb = v;
            REG_Y_BOUNDS:       sh_yb = v;
            REG_TARGET_HEADING: sh_target = v[15:0];
            REG_HEADING_TOL:    sh_tol = v[15:0];
            REG_LEG_AND_SPIN:   sh_leg = v[23:0];
            default:            ;
        endcase
    endtask

    // Build one random pose: mostly unit quaternions near the box, some raw noise
    function automatic logic [103:0] random_pose();
        logic [19:0] px, py;
        logic [15:0] qx, qy, qz, qw;
        real th, ax, ay, az, n, h;
        if ($urandom_range(99) < 70)
        begin
            px = 20'($signed($urandom_range(5000)) - 2500);
            py = 20'($signed($urandom_range(5000)) - 2500);
            th = $urandom * 6.283185307179586 / 4294967296.0;
            h = th / 2.0;
            if ($urandom_range(99) < 80)
            begin
                ax = 0.0;
                ay = 0.0;
                az = 1.0;
            end
            else
            begin
                ax = $urandom_range(2000) - 1000.0;
                ay = $urandom_range(2000) - 1000.0;
                az = $urandom_range(2000) - 1000.0;
                n = $sqrt(ax * ax + ay * ay + az * az) + 1.0e-9;
                ax = ax / n;
                ay = ay / n;
                az = az / n;
            end
            qw = 16'($rtoi(16384.0 * $cos(h)));
            qx = 16'($rtoi(16384.0 * $sin(h) * ax));
            qy = 16'($rtoi(16384.0 * $sin(h) * ay));
            qz = 16'($rtoi(16384.0 * $sin(h) * az));
        end
        else
        begin
            px = 20'($urandom);
            py = 20'($urandom);
            qx = 16'($urandom);
            qy = 16'($urandom);
            qz = 16'($urandom);
            qw = 16'($urandom);
        end
        return {qw, qz, qy, qx, py, px};
    endfunction

    // Random configuration with a box around the origin
    task automatic random_config();
        logic [19:0] lo;
        logic [19:0] hi;
        write_reg(REG_OFFSET_X, 40'($signed($urandom_range(4000)) - 2000));
        write_reg(REG_OFFSET_Y, 40'($signed($urandom_range(4000)) - 2000));
        write_reg(REG_OFFSET_ANGLE, 40'($urandom_range(16'hFFFF)));
        lo = 20'(-$signed($urandom_range(1500)));
        hi = 20'($urandom_range(1500));
        write_reg(REG_X_BOUNDS, {hi, lo});
        lo = 20'(-$signed($urandom_range(1500)));
        hi = 20'($urandom_range(1500));
        write_reg(REG_Y_BOUNDS, {hi, lo});
        write_reg(REG_TARGET_HEADING, 40'($urandom_range(16'hFFFF)));
        write_reg(REG_HEADING_TOL, 40'($urandom_range(8000)));
        write_reg(REG_LEG_AND_SPIN, 40'($urandom_range(24'hFFFFFF)));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        pose_row_t    dir_rows[$];
        pose_row_t    row;
        pose_result_t none;
        none = '0;

        // Directed rows: extremes, box edges, special quaternions
        dir_rows = '{
            '{20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0, '0},
            // gimbal lock at the origin: yaw zero, in the box and aligned, stair leg
            '{20'd0, 20'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 1'b1,
              '{16'd0, 20'sd0, 20'sd0, 1'b1, 1'b1, 8'd0, 8'd2}},
            '{20'd1000, 20'd1000, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0, '0},
            '{20'd1001, 20'd500, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0, '0},
            '{20'hFFFFF, 20'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0, '0},
            '{20'h7FFFF, 20'h7FFFF, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0, '0},
            '{20'h80000, 20'h80000, 16'd0, 16'd0, 16'd0, 16'hC000, 1'b0, '0},
            // zero vector into the arctangent
            '{20'd10, 20'd10, 16'd0, 16'd8192, 16'd8192, 16'd0, 1'b0, '0},
            // half turn about z
            '{20'd20, 20'd20, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b0, '0},
            '{20'd30, 20'd30, 16'd0, 16'd0, 16'hC000, 16'd0, 1'b0, '0},
            // unnormalized quaternion
            '{20'd40, 20'd40, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 1'b0, '0},
            '{20'd50, 20'd50, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
            '{20'd60, 20'd60, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
            '{20'd0, 20'd0, 16'd11585, 16'd0, 16'd0, 16'd11585, 1'b0, '0},
            '{20'd0, 20'd0, 16'd0, 16'd11585, 16'd0, 16'd11585, 1'b0, '0},
            '{20'd999, 20'd0, 16'd0, 16'd0, 16'd1000, 16'd16353, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset configuration
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_pose({row.qw, row.qz, row.qy, row.qx, row.py, row.px}, row.typed, row.want);
        end

        // Random passes, each under its own configuration; passes 0 and 4 share an idling mode
        for (int pass = 0; pass < 5; pass++)
        begin
            drain_pipeline();
            case (pass)
                1:
                begin
                    write_reg(REG_OFFSET_X, 40'h7FFFF);
                    write_reg(REG_OFFSET_Y, 40'h80000);
                    write_reg(REG_OFFSET_ANGLE, 40'hFFFF);
                    write_reg(REG_X_BOUNDS, {20'h7FFFF, 20'h80000});
                    write_reg(REG_Y_BOUNDS, {20'h7FFFF, 20'h80000});
                    write_reg(REG_TARGET_HEADING, 40'h8000);
                    write_reg(REG_HEADING_TOL, 40'd0);
                    write_reg(REG_LEG_AND_SPIN, 40'hFFFFFF);
                    cfg_we <= 1'b0;
                end
                2:
                begin
                    // inverted box on x is never entered
                    write_reg(REG_OFFSET_X, 40'd0);
                    write_reg(REG_OFFSET_Y, 40'd0);
                    write_reg(REG_OFFSET_ANGLE, 40'($urandom_range(16'hFFFF)));
                    write_reg(REG_X_BOUNDS, {20'hFFF9C, 20'd100});
                    write_reg(REG_Y_BOUNDS, {20'h7FFFF, 20'h80000});
                    write_reg(REG_HEADING_TOL, 40'd32768);
                    write_reg(REG_LEG_AND_SPIN, 40'd0);
                    cfg_we <= 1'b0;
                end
                3, 4:
                begin
                    random_config();
                end
                default: ;
            endcase
            case (pass % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct = 27;
                    recv_stall_pct = 27;
                end
            endcase
            if (pass == 4)
            begin
                // tolerance above half a turn always matches
                drain_pipeline();
                write_reg(REG_HEADING_TOL, 40'hFFFF);
                cfg_we <= 1'b0;
            end
            for (int n = 0; n < RAND_PER_PASS; n++)
                send_pose(random_pose(), 1'b0, none);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
